FILE: sv/tld_pkg.sv
// Shared types and telnet constants for the telnet line discipline.
`default_nettype none
package tld_pkg;

  localparam int LEN_W  = 5;
  localparam int STEP_W = 6;

  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_SE   = 8'd240;

  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_DEL   = 8'd127;

  localparam logic [1:0] CH_ECHO = 2'd0;
  localparam logic [1:0] CH_LINE = 2'd1;
  localparam logic [1:0] CH_END  = 2'd2;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_ERASE,
    CMD_LINE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             echo;
  } cmd_t;

endpackage
`default_nettype wire

FILE: sv/tld_front.sv
// Receive front end: telnet command parsing and line length tracking.
`default_nettype none
module tld_front #(
  parameter int DEPTH = 31
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [7:0]   rx_byte_i,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_echo_off_i,
  input  wire logic         q_full_i,
  output logic              push_o,
  output tld_pkg::cmd_t     push_cmd_o
);

  typedef enum logic [1:0] {
    MODE_DATA,
    MODE_CMD,
    MODE_OPT,
    MODE_SUB
  } mode_e;

  mode_e                        mode_q, mode_d;
  logic                         prev_iac_q, prev_iac_d;
  logic                         after_cr_q, after_cr_d;
  logic [tld_pkg::LEN_W-1:0]    len_q, len_d;
  logic                         echo_off_q;
  logic                         accept;
  logic [7:0]                   b;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = rx_byte_i;

  always_comb begin
    mode_d     = mode_q;
    prev_iac_d = prev_iac_q;
    after_cr_d = after_cr_q;
    len_d      = len_q;
    push_o     = 1'b0;
    push_cmd_o = '{kind: tld_pkg::CMD_CHAR, data: b, len: len_q, echo: !echo_off_q};
    if (accept) begin
      unique case (mode_q)
        MODE_SUB: begin
          if (prev_iac_q && b == tld_pkg::TN_SE) begin
            mode_d     = MODE_DATA;
            prev_iac_d = 1'b0;
          end else begin
            prev_iac_d = (b == tld_pkg::TN_IAC);
          end
        end
        MODE_CMD: begin
          after_cr_d = 1'b0;
          if (b == tld_pkg::TN_WILL || b == tld_pkg::TN_WONT ||
              b == tld_pkg::TN_DO || b == tld_pkg::TN_DONT) begin
            mode_d = MODE_OPT;
          end else if (b == tld_pkg::TN_SB) begin
            mode_d     = MODE_SUB;
            prev_iac_d = 1'b0;
          end else begin
            mode_d = MODE_DATA;
          end
        end
        MODE_OPT: begin
          after_cr_d = 1'b0;
          mode_d     = MODE_DATA;
        end
        MODE_DATA: begin
          after_cr_d = 1'b0;
          priority if (after_cr_q && b == tld_pkg::CHAR_LF) begin
            after_cr_d = 1'b0;
          end else if (b == tld_pkg::TN_IAC) begin
            mode_d = MODE_CMD;
          end else if (b == tld_pkg::CHAR_CR || b == tld_pkg::CHAR_LF) begin
            after_cr_d      = (b == tld_pkg::CHAR_CR);
            push_o          = 1'b1;
            push_cmd_o.kind = tld_pkg::CMD_LINE;
            len_d           = '0;
          end else if (b == tld_pkg::CHAR_BS || b == tld_pkg::CHAR_DEL) begin
            if (len_q != '0) begin
              len_d           = len_q - tld_pkg::LEN_W'(1);
              push_o          = !echo_off_q;
              push_cmd_o.kind = tld_pkg::CMD_ERASE;
            end
          end else if (b >= tld_pkg::CHAR_SPACE) begin
            if (len_q < tld_pkg::LEN_W'(DEPTH)) begin
              len_d  = len_q + tld_pkg::LEN_W'(1);
              push_o = 1'b1;
            end
          end else begin
            // Other control bytes are dropped.
            after_cr_d = 1'b0;
          end
        end
        default: mode_d = MODE_DATA;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_DATA;
      prev_iac_q <= 1'b0;
      after_cr_q <= 1'b0;
      len_q      <= '0;
      echo_off_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      prev_iac_q <= prev_iac_d;
      after_cr_q <= after_cr_d;
      len_q      <= len_d;
      if (cfg_valid_i) begin
        echo_off_q <= cfg_echo_off_i;
      end
    end
  end

  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= tld_pkg::LEN_W'(DEPTH))
    else $error("line length beyond store depth");

endmodule
`default_nettype wire

FILE: sv/tld_queue.sv
// Two-entry command queue between the front end and the output sequencer.
`default_nettype none
module tld_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tld_pkg::cmd_t  push_cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output tld_pkg::cmd_t       head_o
);

  tld_pkg::cmd_t  entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("command popped from an empty queue");

endmodule
`default_nettype wire

FILE: sv/tld_back.sv
// Output sequencer: line store, echo and line flush result generation.
`default_nettype none
module tld_back #(
  parameter int DEPTH = 31
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire tld_pkg::cmd_t  q_head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          channel_o,
  output logic [7:0]          out_byte_o,
  output logic                last_o
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                      state_q;
  tld_pkg::cmd_t               cmd_q;
  logic [tld_pkg::STEP_W-1:0]  step_q;
  logic [tld_pkg::STEP_W-1:0]  end_step;
  logic [tld_pkg::LEN_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic [IDX_W-1:0]            rd_addr;
  logic [7:0]                  store_q [DEPTH];
  logic [7:0]                  rd_data_q;
  logic                        emit;
  logic [1:0]                  ch_n;
  logic [7:0]                  byte_n;
  logic                        last_n;
  logic                        out_valid_q;
  logic [1:0]                  channel_q;
  logic [7:0]                  out_byte_q;
  logic                        last_q;

  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i;
  assign emit     = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  assign end_step = {1'b0, cmd_q.len} + tld_pkg::STEP_W'(2);

  always_comb begin
    ch_n     = tld_pkg::CH_ECHO;
    byte_n   = cmd_q.data;
    last_n   = 1'b1;
    rd_cnt_d = rd_cnt_q;
    unique case (cmd_q.kind)
      tld_pkg::CMD_CHAR: begin
        last_n = 1'b1;
      end
      tld_pkg::CMD_ERASE: begin
        byte_n = (step_q == tld_pkg::STEP_W'(1)) ? tld_pkg::CHAR_SPACE : tld_pkg::CHAR_BS;
        last_n = (step_q == tld_pkg::STEP_W'(2));
      end
      tld_pkg::CMD_LINE: begin
        last_n = (step_q == end_step);
        if (step_q == tld_pkg::STEP_W'(0)) begin
          byte_n = tld_pkg::CHAR_CR;
        end else if (step_q == tld_pkg::STEP_W'(1)) begin
          byte_n = tld_pkg::CHAR_LF;
        end else if (last_n) begin
          ch_n   = tld_pkg::CH_END;
          byte_n = 8'd0;
        end else begin
          ch_n   = tld_pkg::CH_LINE;
          byte_n = rd_data_q;
          if (emit) begin
            rd_cnt_d = rd_cnt_q + tld_pkg::LEN_W'(1);
          end
        end
      end
      default: begin
        last_n = 1'b1;
      end
    endcase
    if (pop_o) begin
      rd_cnt_d = '0;
    end
  end

  assign rd_addr = (rd_cnt_d < tld_pkg::LEN_W'(DEPTH)) ? rd_cnt_d[IDX_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (pop_o && q_head_i.kind == tld_pkg::CMD_CHAR) begin
      store_q[q_head_i.len[IDX_W-1:0]] <= q_head_i.data;
    end
    rd_data_q <= store_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_head_i;
    end
    if (emit) begin
      channel_q  <= ch_n;
      out_byte_q <= byte_n;
      last_q     <= last_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_cnt_q <= rd_cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (pop_o && (q_head_i.kind != tld_pkg::CMD_CHAR || q_head_i.echo)) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit) begin
            step_q <= step_q + tld_pkg::STEP_W'(1);
            if (last_n) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign channel_o   = channel_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  a_store_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && q_head_i.kind == tld_pkg::CMD_CHAR) |-> q_head_i.len < tld_pkg::LEN_W'(DEPTH))
    else $error("character written beyond the line store");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cmd_q.kind == tld_pkg::CMD_LINE) |-> step_q <= end_step)
    else $error("line flush ran past its end marker");

endmodule
`default_nettype wire

FILE: sv/telnet_line_discipline_core.sv
// Top level of the telnet receive line discipline.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         in_valid_i / in_ready_o    rx_byte_i
//   result    out        out_valid_o / out_ready_i  channel_o, out_byte_o, last_o
//   config    in         cfg_valid_i / cfg_ready_o  cfg_echo_off_i
//
// A byte is taken by the front end; one that causes results has its command picked up
// from the queue by the output sequencer, which then produces its results one after
// another.
// The sequencer emits at most one result per cycle through its output register.
// Input stalls only when the two-entry command queue is full; output stalls hold the
// sequencer. Reset clears the parse state and the line length; the line store is not
// cleared, since only written entries are ever read.
`default_nettype none
module telnet_line_discipline_core #(
  parameter int LINE_MAX = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       channel_o,
  output logic [7:0]       out_byte_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_echo_off_i
);

  localparam int STORE_DEPTH = (LINE_MAX - 1 < 31) ? LINE_MAX - 1 : 31;

  logic           q_full, q_empty, push, pop;
  tld_pkg::cmd_t  push_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;

  tld_front #(
    .DEPTH(STORE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_echo_off_i(cfg_echo_off_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_cmd_o    (push_cmd)
  );

  tld_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (q_full),
    .pop_i     (pop),
    .empty_o   (q_empty),
    .head_o    (head_cmd)
  );

  tld_back #(
    .DEPTH(STORE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (head_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .channel_o  (channel_o),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule
`default_nettype wire

FILE: sim/tb_telnet_line_discipline_core.sv
// Self-checking testbench for the telnet receive line discipline core.
module tb_telnet_line_discipline_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX      = 32;
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT   = 2000;
  localparam int DIRECTED_ROWS = 25;
  localparam int PHASE_BYTES   = 45;

  typedef enum logic [1:0] {
    MODE_DATA,
    MODE_CMD,
    MODE_OPT,
    MODE_SUB
  } rx_mode_e;

  typedef enum int {
    SEQ_WORD,
    SEQ_ERASE,
    SEQ_LINE_END,
    SEQ_OPTION,
    SEQ_COMMAND,
    SEQ_SUBNEG,
    SEQ_LONG_LINE,
    SEQ_NOISE
  } seq_kind_e;

  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] data;
    logic       last;
  } line_result_t;

  typedef struct packed {
    logic [7:0]              rx;
    logic                    typed;
    logic [1:0]              nexp;
    line_result_t [0:2]      want;
  } stim_row_t;

  localparam line_result_t ECHO_CR  =
    line_result_t'{tld_pkg::CH_ECHO, tld_pkg::CHAR_CR, 1'b0};
  localparam line_result_t ECHO_LF  =
    line_result_t'{tld_pkg::CH_ECHO, tld_pkg::CHAR_LF, 1'b0};
  localparam line_result_t ECHO_BS  =
    line_result_t'{tld_pkg::CH_ECHO, tld_pkg::CHAR_BS, 1'b0};
  localparam line_result_t ECHO_SP  =
    line_result_t'{tld_pkg::CH_ECHO, tld_pkg::CHAR_SPACE, 1'b0};
  localparam line_result_t END_LAST =
    line_result_t'{tld_pkg::CH_END, 8'h00, 1'b1};

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i      = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [1:0] channel_o;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic       cfg_valid_i    = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_echo_off_i = 1'b0;

  rx_mode_e   ed_mode      = MODE_DATA;
  logic       ed_sub_iac   = 1'b0;
  logic       ed_after_cr  = 1'b0;
  logic       ed_echo_off  = 1'b0;
  logic [7:0] ed_line [LINE_MAX-1];
  int         ed_len       = 0;

  line_result_t step_out [$];
  line_result_t pending_results [$];

  int unsigned in_idle_pct     = 0;
  int unsigned out_stall_pct   = 0;
  int unsigned mismatches      = 0;
  int unsigned bytes_fed       = 0;
  int unsigned results_checked = 0;
  int unsigned lines_flushed   = 0;
  int unsigned quiet_cycles    = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{tld_pkg::CHAR_BS,    1'b1, 2'd0, '0},
    '{8'h00,               1'b1, 2'd0, '0},
    '{tld_pkg::CHAR_CR,    1'b1, 2'd3, {ECHO_CR, ECHO_LF, END_LAST}},
    '{tld_pkg::CHAR_LF,    1'b1, 2'd0, '0},
    '{tld_pkg::CHAR_SPACE, 1'b1, 2'd1,
      {line_result_t'{tld_pkg::CH_ECHO, tld_pkg::CHAR_SPACE, 1'b1}, 22'h0}},
    '{8'hFE,               1'b1, 2'd1,
      {line_result_t'{tld_pkg::CH_ECHO, 8'hFE, 1'b1}, 22'h0}},
    '{tld_pkg::CHAR_DEL,   1'b1, 2'd3,
      {ECHO_BS, ECHO_SP, line_result_t'{tld_pkg::CH_ECHO, tld_pkg::CHAR_BS, 1'b1}}},
    '{tld_pkg::TN_IAC,     1'b1, 2'd0, '0},
    '{tld_pkg::TN_IAC,     1'b1, 2'd0, '0},
    '{tld_pkg::TN_IAC,     1'b1, 2'd0, '0},
    '{tld_pkg::TN_WILL,    1'b1, 2'd0, '0},
    '{8'h01,               1'b1, 2'd0, '0},
    '{tld_pkg::TN_IAC,     1'b1, 2'd0, '0},
    '{8'h05,               1'b1, 2'd0, '0},
    '{tld_pkg::TN_IAC,     1'b1, 2'd0, '0},
    '{tld_pkg::TN_SB,      1'b1, 2'd0, '0},
    '{8'h41,               1'b1, 2'd0, '0},
    '{tld_pkg::TN_IAC,     1'b1, 2'd0, '0},
    '{tld_pkg::TN_IAC,     1'b1, 2'd0, '0},
    '{tld_pkg::TN_SE,      1'b1, 2'd0, '0},
    '{8'h1F,               1'b1, 2'd0, '0},
    '{tld_pkg::CHAR_LF,    1'b0, 2'd0, '0},
    '{tld_pkg::CHAR_CR,    1'b0, 2'd0, '0},
    '{tld_pkg::TN_IAC,     1'b0, 2'd0, '0},
    '{tld_pkg::CHAR_LF,    1'b0, 2'd0, '0}
  };

  telnet_line_discipline_core #(
    .LINE_MAX(LINE_MAX)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .channel_o     (channel_o),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_echo_off_i(cfg_echo_off_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void edit_byte(input logic [7:0] b);
    step_out.delete();
    case (ed_mode)
      MODE_SUB: begin
        if (ed_sub_iac && b == tld_pkg::TN_SE) begin
          ed_mode    = MODE_DATA;
          ed_sub_iac = 1'b0;
        end else begin
          ed_sub_iac = (b == tld_pkg::TN_IAC);
        end
      end
      MODE_CMD: begin
        ed_after_cr = 1'b0;
        if (b == tld_pkg::TN_WILL || b == tld_pkg::TN_WONT ||
            b == tld_pkg::TN_DO || b == tld_pkg::TN_DONT) begin
          ed_mode = MODE_OPT;
        end else if (b == tld_pkg::TN_SB) begin
          ed_mode    = MODE_SUB;
          ed_sub_iac = 1'b0;
        end else begin
          ed_mode = MODE_DATA;
        end
      end
      MODE_OPT: begin
        ed_after_cr = 1'b0;
        ed_mode     = MODE_DATA;
      end
      default: begin
        if (ed_after_cr && b == tld_pkg::CHAR_LF) begin
          ed_after_cr = 1'b0;
        end else begin
          ed_after_cr = 1'b0;
          if (b == tld_pkg::TN_IAC) begin
            ed_mode = MODE_CMD;
          end else if (b == tld_pkg::CHAR_CR || b == tld_pkg::CHAR_LF) begin
            ed_after_cr = (b == tld_pkg::CHAR_CR);
            step_out.push_back(ECHO_CR);
            step_out.push_back(ECHO_LF);
            for (int i = 0; i < ed_len; i++) begin
              step_out.push_back(line_result_t'{tld_pkg::CH_LINE, ed_line[i], 1'b0});
            end
            step_out.push_back(line_result_t'{tld_pkg::CH_END, 8'h00, 1'b0});
            ed_len = 0;
          end else if (b == tld_pkg::CHAR_BS || b == tld_pkg::CHAR_DEL) begin
            if (ed_len > 0) begin
              ed_len--;
              if (!ed_echo_off) begin
                step_out.push_back(ECHO_BS);
                step_out.push_back(ECHO_SP);
                step_out.push_back(ECHO_BS);
              end
            end
          end else if (b >= tld_pkg::CHAR_SPACE) begin
            if (ed_len < LINE_MAX - 1) begin
              ed_line[ed_len] = b;
              ed_len++;
              if (!ed_echo_off) begin
                step_out.push_back(line_result_t'{tld_pkg::CH_ECHO, b, 1'b0});
              end
            end
          end
        end
      end
    endcase
    if (step_out.size() != 0) begin
      step_out[step_out.size()-1].last = 1'b1;
    end
  endfunction

  task automatic feed_byte(input stim_row_t row);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= row.rx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    edit_byte(row.rx);
    if (row.typed) begin
      for (int i = 0; i < row.nexp; i++) pending_results.push_back(row.want[i]);
    end else begin
      foreach (step_out[i]) pending_results.push_back(step_out[i]);
    end
    bytes_fed++;
  endtask

  task automatic feed_plain(input logic [7:0] b);
    stim_row_t row;
    row    = '0;
    row.rx = b;
    feed_byte(row);
  endtask

  function automatic logic [7:0] printable_byte();
    logic [7:0] b;
    b = 8'($urandom_range(254, 32));
    if (b == tld_pkg::CHAR_DEL) b = 8'h7E;
    return b;
  endfunction

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_echo_off(input logic value);
    wait_idle();
    cfg_valid_i    <= 1'b1;
    cfg_echo_off_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    ed_echo_off = value;
  endtask

  task automatic feed_random_phase(input int unsigned target);
    int unsigned start;
    int          pick;
    int          count;
    seq_kind_e   kind;
    start = bytes_fed;
    kind  = SEQ_LONG_LINE;
    while (bytes_fed - start < target) begin
      case (kind)
        SEQ_WORD: begin
          count = $urandom_range(8, 1);
          repeat (count) feed_plain(printable_byte());
        end
        SEQ_ERASE: begin
          count = $urandom_range(3, 1);
          repeat (count) begin
            feed_plain($urandom_range(1) ? tld_pkg::CHAR_BS : tld_pkg::CHAR_DEL);
          end
        end
        SEQ_LINE_END: begin
          pick = $urandom_range(2);
          if (pick != 1) feed_plain(tld_pkg::CHAR_CR);
          if (pick != 0) feed_plain(tld_pkg::CHAR_LF);
        end
        SEQ_OPTION: begin
          feed_plain(tld_pkg::TN_IAC);
          feed_plain(8'($urandom_range(tld_pkg::TN_DONT, tld_pkg::TN_WILL)));
          feed_plain(8'($urandom_range(255)));
        end
        SEQ_COMMAND: begin
          feed_plain(tld_pkg::TN_IAC);
          feed_plain(8'($urandom_range(255)));
        end
        SEQ_SUBNEG: begin
          feed_plain(tld_pkg::TN_IAC);
          feed_plain(tld_pkg::TN_SB);
          count = $urandom_range(6);
          repeat (count) begin
            feed_plain(($urandom_range(3) == 0) ? tld_pkg::TN_IAC
                                                : 8'($urandom_range(255)));
          end
          feed_plain(tld_pkg::TN_IAC);
          feed_plain(tld_pkg::TN_SE);
        end
        SEQ_LONG_LINE: begin
          count = $urandom_range(36, 30);
          repeat (count) feed_plain(printable_byte());
          feed_plain(tld_pkg::CHAR_CR);
        end
        default: feed_plain(8'($urandom_range(255)));
      endcase
      pick = $urandom_range(99);
      if (pick < 30)      kind = SEQ_WORD;
      else if (pick < 42) kind = SEQ_ERASE;
      else if (pick < 57) kind = SEQ_LINE_END;
      else if (pick < 67) kind = SEQ_OPTION;
      else if (pick < 74) kind = SEQ_COMMAND;
      else if (pick < 82) kind = SEQ_SUBNEG;
      else if (pick < 86) kind = SEQ_LONG_LINE;
      else                kind = SEQ_NOISE;
    end
  endtask

  always @(posedge clk_i) begin
    line_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: channel %0d, byte 0x%02h, last %0b",
               channel_o, out_byte_o, last_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (channel_o !== want.channel) begin
          $error("channel: expected %0d, got %0d", want.channel, channel_o);
          mismatches++;
        end
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.data, out_byte_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          mismatches++;
        end
      end
      results_checked++;
      if (channel_o == tld_pkg::CH_END) lines_flushed++;
    end
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned p;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    in_idle_pct   = 6;
    out_stall_pct = 55;
    write_echo_off(1'b0);
    foreach (directed_rows[i]) feed_byte(directed_rows[i]);

    for (p = 0; p < 3; p++) begin
      in_idle_pct   = (p == 0) ? 6 : (p == 1) ? 55 : 0;
      out_stall_pct = (p == 0) ? 55 : (p == 1) ? 6 : 0;
      write_echo_off((p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(1)));
      feed_random_phase(PHASE_BYTES);
    end

    wait_idle();
    $display("Fed %0d bytes with echo on and off under three idling profiles;",
             bytes_fed);
    $display("checked %0d results including %0d line flushes.",
             results_checked, lines_flushed);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tld_pkg.sv
sv/tld_front.sv
sv/tld_queue.sv
sv/tld_back.sv
sv/telnet_line_discipline_core.sv
sim/tb_telnet_line_discipline_core.sv
